// ===== hw/rtl/etl_pkg.sv =====
// Shared types and constants for the escaped token lexer.
// No dependencies; imported by every module of the block.
`default_nettype none

package etl_pkg;

  // Widest character the block takes, in bytes
  localparam int MAX_CHAR_BYTES = 4;

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Lexer phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BODY  = 3'd1,
    PH_QBODY = 3'd2,
    PH_ESC   = 3'd3,
    PH_HEX1  = 3'd4,
    PH_HEX2  = 3'd5
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_CONT = 2'd0,
    ST_QEND = 2'd1,
    ST_DEND = 2'd2,
    ST_ERR  = 2'd3
  } status_t;

  // Classified character handed from front to back
  typedef struct packed {
    logic [31:0] bytes;     // masked to len bytes
    logic [2:0]  len;       // normalized byte count, 1..MAX_CHAR_BYTES
    logic [7:0]  b0;        // first byte
    logic        single;    // one-byte character
    logic        is_ws;     // single and whitespace
    logic        is_delim;  // single and token delimiter
    logic        is_bslash; // single backslash
    logic        is_quote;  // single ' or "
    logic        is_x;      // single x or X
    logic        hex_ok;    // single hex digit
    logic [3:0]  hex_val;
    logic [7:0]  esc_byte;  // byte produced when escaped
  } cls_t;

endpackage

`default_nettype wire

// ===== hw/rtl/etl_front.sv =====
// Front part: normalizes one incoming character and classifies its first byte.
// Depends on etl_pkg.
`default_nettype none

module etl_front import etl_pkg::*; (
  input  logic [31:0] char_bytes,
  input  logic [2:0]  char_len,
  output cls_t        cls
);

  logic [2:0]  len_n;
  logic [31:0] masked;
  logic [7:0]  b0;
  logic        single;
  logic        ws;

  // Clamp the byte count into 1..MAX_CHAR_BYTES
  always_comb begin
    if (char_len == 3'd0) begin
      len_n = 3'd1;
    end else if (char_len > 3'(MAX_CHAR_BYTES)) begin
      len_n = 3'(MAX_CHAR_BYTES);
    end else begin
      len_n = char_len;
    end
  end

  // Drop bytes above the count
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      masked[8*i +: 8] = (3'(i) < len_n) ? char_bytes[8*i +: 8] : 8'h00;
    end
  end

  assign b0     = masked[7:0];
  assign single = (len_n == 3'd1);
  assign ws     = (b0 == 8'h20) || (b0 >= 8'h09 && b0 <= 8'h0D);

  // Classify the first byte
  always_comb begin
    cls.bytes     = masked;
    cls.len       = len_n;
    cls.b0        = b0;
    cls.single    = single;
    cls.is_ws     = single && ws;
    cls.is_delim  = single && (ws || b0 == "=" || b0 == "(" || b0 == ")" ||
                    b0 == "[" || b0 == "]" || b0 == "{" || b0 == "}" ||
                    b0 == "<" || b0 == ">" || b0 == ";" || b0 == "," ||
                    b0 == "/");
    cls.is_bslash = single && (b0 == 8'h5C);
    cls.is_quote  = single && (b0 == 8'h27 || b0 == 8'h22);
    cls.is_x      = single && (b0 == "x" || b0 == "X");
    cls.hex_ok    = 1'b0;
    cls.hex_val   = 4'd0;
    if (b0 >= "0" && b0 <= "9") begin
      cls.hex_ok  = single;
      cls.hex_val = 4'(b0 - 8'h30);
    end else if (b0 >= "a" && b0 <= "f") begin
      cls.hex_ok  = single;
      cls.hex_val = 4'(b0 - 8'h57);
    end else if (b0 >= "A" && b0 <= "F") begin
      cls.hex_ok  = single;
      cls.hex_val = 4'(b0 - 8'h37);
    end
    case (b0)
      "n":     cls.esc_byte = 8'h0A;
      "r":     cls.esc_byte = 8'h0D;
      "t":     cls.esc_byte = 8'h09;
      "b":     cls.esc_byte = 8'h08;
      "f":     cls.esc_byte = 8'h0C;
      default: cls.esc_byte = b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/etl_queue.sv =====
// Short queue of classified characters between front and back.
// Depends on etl_pkg.
`default_nettype none

module etl_queue import etl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  cls_t  push_data,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output cls_t  head
);

  cls_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  // Store a pushed request
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/etl_back.sv =====
// Back part: lexer state machine and registered result output.
// Depends on etl_pkg.
`default_nettype none

module etl_back import etl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cls_t        c,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_bytes,
  output logic [2:0]  out_count,
  output logic [1:0]  status
);

  phase_t      phase, phase_next;
  logic        in_quotes, in_quotes_next;
  logic [7:0]  closing_quote, closing_quote_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [31:0] ob;
  logic [2:0]  oc;
  status_t     st;
  logic        body;
  logic        fire;

  // Take the head request whenever the output register can load
  assign fire  = q_valid && (!out_valid || !out_stall);
  assign q_pop = fire;

  // Next state and result for the head character
  always_comb begin
    phase_next         = phase;
    in_quotes_next     = in_quotes;
    closing_quote_next = closing_quote;
    high_nibble_next   = high_nibble;
    ob                 = 32'h0;
    oc                 = 3'd0;
    st                 = ST_CONT;
    body               = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (!c.is_ws) begin
          if (c.is_quote) begin
            in_quotes_next     = 1'b1;
            closing_quote_next = c.b0;
            phase_next         = PH_QBODY;
          end else begin
            in_quotes_next = 1'b0;
            phase_next     = PH_BODY;
            body           = 1'b1;
          end
        end
      end
      PH_BODY: begin
        body = 1'b1;
      end
      PH_QBODY: begin
        if (c.is_bslash) begin
          phase_next = PH_ESC;
        end else if (c.single && c.b0 == closing_quote) begin
          st = ST_QEND;
        end else begin
          ob = c.bytes;
          oc = c.len;
        end
      end
      PH_ESC: begin
        if (!c.single) begin
          ob         = c.bytes;
          oc         = c.len;
          phase_next = in_quotes ? PH_QBODY : PH_BODY;
        end else if (c.is_x) begin
          phase_next = PH_HEX1;
        end else begin
          ob         = 32'(c.esc_byte);
          oc         = 3'd1;
          phase_next = in_quotes ? PH_QBODY : PH_BODY;
        end
      end
      PH_HEX1: begin
        if (c.hex_ok) begin
          high_nibble_next = c.hex_val;
          phase_next       = PH_HEX2;
        end else begin
          st = ST_ERR;
        end
      end
      PH_HEX2: begin
        if (c.hex_ok) begin
          ob         = 32'({high_nibble, c.hex_val});
          oc         = 3'd1;
          phase_next = in_quotes ? PH_QBODY : PH_BODY;
        end else begin
          st = ST_ERR;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // Unquoted body, also for the character that opens the token
    if (body) begin
      if (c.is_bslash) begin
        phase_next = PH_ESC;
      end else if (c.is_delim) begin
        st = ST_DEND;
      end else begin
        ob = c.bytes;
        oc = c.len;
      end
    end

    // Drop back to idle on any end or error
    if (st != ST_CONT) begin
      phase_next = PH_IDLE;
      ob         = 32'h0;
      oc         = 3'd0;
    end
  end

  // Lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      in_quotes     <= 1'b0;
      closing_quote <= 8'h00;
      high_nibble   <= 4'h0;
    end else if (fire) begin
      phase         <= phase_next;
      in_quotes     <= in_quotes_next;
      closing_quote <= closing_quote_next;
      high_nibble   <= high_nibble_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_bytes <= ob;
      out_count <= oc;
      status    <= st;
    end
  end

  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_CONT |-> out_count == 3'd0 && out_bytes == 32'h0)
    else $error("end or error result carries bytes");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    fire && st != ST_CONT |=> phase == PH_IDLE)
    else $error("phase not idle after end or error");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count <= 3'(MAX_CHAR_BYTES))
    else $error("result byte count too large");

endmodule

`default_nettype wire

// ===== hw/rtl/escaped_token_lexer.sv =====
// Escaped string token lexer, top level.
// Instantiates etl_front, etl_queue and etl_back; depends on etl_pkg.
//
// Input channel: in_valid / in_stall with char_bytes (first byte in bits 7:0)
// and char_len. One UTF-8 character per request. in_stall rises only when the
// two-entry queue between front and back is full.
// Output channel: out_valid / out_stall with out_bytes, out_count and status
// (continue, quoted end, delimiter end, error). Every accepted character
// yields exactly one result, in order.
// Each accepted character is written into the queue; its result is then
// loaded into the output register.
// Throughput: one character per cycle while out_stall is low, set by the single
// state transition in the back part, which handles one queued character per cycle.
// Reset (rst, synchronous, active high): the lexer goes to idle, skipping
// whitespace; the queue and output register are emptied.
// When out_stall is held, the output register holds its result, the back
// part stops, the queue fills and then in_stall holds off the sender. No
// request is lost or repeated.
`default_nettype none

module escaped_token_lexer import etl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] char_bytes,
  input  logic [2:0]  char_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_bytes,
  output logic [2:0]  out_count,
  output logic [1:0]  status
);

  cls_t cls;
  cls_t head;
  logic full;
  logic not_empty;
  logic pop;
  logic push;

  assign in_stall = full;
  assign push     = in_valid && !full;

  // Classify the incoming character
  etl_front u_front (
    .char_bytes (char_bytes),
    .char_len   (char_len),
    .cls        (cls)
  );

  // Buffer classified requests
  etl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cls),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  // Run the lexer and register results
  etl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (not_empty),
    .c         (head),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_bytes (out_bytes),
    .out_count (out_count),
    .status    (status)
  );

endmodule

`default_nettype wire
